FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled during reset
`define MCK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("keyer assertion failed");
// Clocked assertion, checked during reset as well
`define MCK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keyer assertion failed");
`else
`define MCK_ASSERT(lbl, clk, rst, prop)
`define MCK_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/mck_pkg.sv
// ---------------------------------------------------------------------------
// mck_pkg
// Types, constants, Morse table and microprogram of the character keyer.
// ---------------------------------------------------------------------------
package mck_pkg;

  localparam int DotW  = 10;
  localparam int DurW  = 13;
  localparam int UnitW = 3;
  localparam int PcW   = 4;
  localparam int CntW  = 3;
  localparam int BitsW = 5;

  localparam logic [DotW-1:0] DotReset = 10'd60;

  // Configuration register indexes
  localparam logic REG_DOT_TIME = 1'b0;

  // Fixed codes for the SOS prosign (length in low 3 bits, elements above)
  localparam logic [7:0] SosS    = 8'b0000_0011;
  localparam logic [7:0] SosO    = 8'b0011_1011;
  localparam logic [2:0] LenMask = 3'h7;

  localparam logic [UnitW-1:0] UnitDot     = 3'd1;
  localparam logic [UnitW-1:0] UnitDash    = 3'd3;
  localparam logic [UnitW-1:0] UnitLetGap  = 3'd3;
  localparam logic [UnitW-1:0] UnitWordGap = 3'd7;
  localparam logic [5:0]       DigitCount  = 6'd10;

  // Microprogram entry points
  localparam logic [PcW-1:0] PcChr = 4'd0;
  localparam logic [PcW-1:0] PcSos = 4'd4;

  typedef enum logic [1:0] {
    LD_NONE = 2'd0,
    LD_CHAR = 2'd1,
    LD_S    = 2'd2,
    LD_O    = 2'd3
  } ld_sel_t;

  typedef enum logic [2:0] {
    EM_NONE     = 3'd0,
    EM_ELEM_ON  = 3'd1,
    EM_OFF_UNIT = 3'd2,
    EM_CHAR_GAP = 3'd3,
    EM_WORD_GAP = 3'd4
  } emit_sel_t;

  typedef enum logic [1:0] {
    J_NEXT    = 2'd0,
    J_ZERO    = 2'd1,
    J_NONZERO = 2'd2,
    J_END     = 2'd3
  } jmp_sel_t;

  typedef struct packed {
    ld_sel_t        ld;
    emit_sel_t      emit;
    jmp_sel_t       jmp;
    logic [PcW-1:0] target;
    logic           last;
  } ucw_t;

  // Segment request from sequencer to output stage
  typedef struct packed {
    logic             valid;
    logic             key_on;
    logic [UnitW-1:0] units;
    logic             last;
  } seg_req_t;

  function automatic ucw_t mk_ucw(ld_sel_t ld, emit_sel_t em, jmp_sel_t j,
                                  logic [PcW-1:0] tgt, logic lst);
    ucw_t w;
    w.ld     = ld;
    w.emit   = em;
    w.jmp    = j;
    w.target = tgt;
    w.last   = lst;
    return w;
  endfunction

  // Microprogram: each step emits at most one segment
  function automatic ucw_t ucode(logic [PcW-1:0] pc);
    ucw_t w;
    unique case (pc)
      // character: load code, element loop, gap
      4'd0:    w = mk_ucw(LD_CHAR, EM_NONE,     J_ZERO,    4'd3,  1'b0);
      4'd1:    w = mk_ucw(LD_NONE, EM_ELEM_ON,  J_NEXT,    4'd0,  1'b0);
      4'd2:    w = mk_ucw(LD_NONE, EM_OFF_UNIT, J_NONZERO, 4'd1,  1'b0);
      4'd3:    w = mk_ucw(LD_NONE, EM_CHAR_GAP, J_END,     4'd0,  1'b1);
      // SOS: S, O, S run together, then word gap
      4'd4:    w = mk_ucw(LD_S,    EM_NONE,     J_NEXT,    4'd0,  1'b0);
      4'd5:    w = mk_ucw(LD_NONE, EM_ELEM_ON,  J_NEXT,    4'd0,  1'b0);
      4'd6:    w = mk_ucw(LD_NONE, EM_OFF_UNIT, J_NONZERO, 4'd5,  1'b0);
      4'd7:    w = mk_ucw(LD_O,    EM_NONE,     J_NEXT,    4'd0,  1'b0);
      4'd8:    w = mk_ucw(LD_NONE, EM_ELEM_ON,  J_NEXT,    4'd0,  1'b0);
      4'd9:    w = mk_ucw(LD_NONE, EM_OFF_UNIT, J_NONZERO, 4'd8,  1'b0);
      4'd10:   w = mk_ucw(LD_S,    EM_NONE,     J_NEXT,    4'd0,  1'b0);
      4'd11:   w = mk_ucw(LD_NONE, EM_ELEM_ON,  J_NEXT,    4'd0,  1'b0);
      4'd12:   w = mk_ucw(LD_NONE, EM_OFF_UNIT, J_NONZERO, 4'd11, 1'b0);
      4'd13:   w = mk_ucw(LD_NONE, EM_WORD_GAP, J_END,     4'd0,  1'b1);
      default: w = mk_ucw(LD_NONE, EM_NONE,     J_END,     4'd0,  1'b0);
    endcase
    return w;
  endfunction

  // International Morse: digits 0-9 then letters A-Z
  function automatic logic [7:0] morse_rom(logic [5:0] idx);
    logic [7:0] v;
    unique case (idx)
      6'd0:  v = 8'hFD; 6'd1:  v = 8'hF5; 6'd2:  v = 8'hE5; 6'd3:  v = 8'hC5;
      6'd4:  v = 8'h85; 6'd5:  v = 8'h05; 6'd6:  v = 8'h0D; 6'd7:  v = 8'h1D;
      6'd8:  v = 8'h3D; 6'd9:  v = 8'h7D; 6'd10: v = 8'h12; 6'd11: v = 8'h0C;
      6'd12: v = 8'h2C; 6'd13: v = 8'h0B; 6'd14: v = 8'h01; 6'd15: v = 8'h24;
      6'd16: v = 8'h1B; 6'd17: v = 8'h04; 6'd18: v = 8'h02; 6'd19: v = 8'h74;
      6'd20: v = 8'h2B; 6'd21: v = 8'h14; 6'd22: v = 8'h1A; 6'd23: v = 8'h0A;
      6'd24: v = 8'h3B; 6'd25: v = 8'h34; 6'd26: v = 8'h5C; 6'd27: v = 8'h13;
      6'd28: v = 8'h03; 6'd29: v = 8'h09; 6'd30: v = 8'h23; 6'd31: v = 8'h44;
      6'd32: v = 8'h33; 6'd33: v = 8'h4C; 6'd34: v = 8'h6C; 6'd35: v = 8'h1C;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Code for one ASCII character; zero length when it has no Morse form
  function automatic logic [7:0] char_code_lookup(logic [7:0] c);
    logic [7:0] code;
    code = 8'h00;
    if (c >= "0" && c <= "9") begin
      code = morse_rom(6'(c - 8'h30));
    end else if (c >= "A" && c <= "Z") begin
      code = morse_rom(DigitCount + 6'(c - 8'h41));
    end else if (c >= "a" && c <= "z") begin
      code = morse_rom(DigitCount + 6'(c - 8'h61));
    end
    return code;
  endfunction

endpackage

FILE: rtl/core/mck_useq.sv
// ---------------------------------------------------------------------------
// mck_useq
// Microcoded sequencer: walks the keying program and requests segments.
// ---------------------------------------------------------------------------
module mck_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  logic [7:0]        char_code,
  input  logic              slot_free,
  output logic              busy,
  output mck_pkg::seg_req_t seg
);
  import mck_pkg::*;

  logic [PcW-1:0]   pc;
  logic [PcW-1:0]   pc_next;
  logic [7:0]       char_r;
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  cnt_next;
  logic [BitsW-1:0] bits;
  logic [BitsW-1:0] bits_next;
  logic [7:0]       ld_code;
  ucw_t             uw;
  logic             emits;
  logic             advance;
  logic             taken;

  assign uw      = ucode(pc);
  assign emits   = (uw.emit != EM_NONE);
  assign advance = busy && (!emits || slot_free);

  // element register load / shift
  always_comb begin
    unique case (uw.ld)
      LD_CHAR: ld_code = char_code_lookup(char_r);
      LD_S:    ld_code = SosS;
      LD_O:    ld_code = SosO;
      default: ld_code = 8'h00;
    endcase
    cnt_next  = cnt;
    bits_next = bits;
    if (uw.ld != LD_NONE) begin
      cnt_next  = ld_code[2:0] & LenMask;
      bits_next = ld_code[7:3];
    end else if (uw.emit == EM_OFF_UNIT) begin
      cnt_next  = cnt - 3'd1;
      bits_next = bits >> 1;
    end
  end

  // branch condition on the updated element count
  always_comb begin
    unique case (uw.jmp)
      J_ZERO:    taken = (cnt_next == '0);
      J_NONZERO: taken = (cnt_next != '0);
      default:   taken = 1'b0;
    endcase
    pc_next = taken ? uw.target : pc + 4'd1;
  end

  // segment request
  always_comb begin
    seg.valid  = busy && emits;
    seg.last   = uw.last;
    seg.key_on = 1'b0;
    unique case (uw.emit)
      EM_ELEM_ON: begin
        seg.key_on = 1'b1;
        seg.units  = bits[0] ? UnitDash : UnitDot;
      end
      EM_OFF_UNIT: seg.units = UnitDot;
      EM_CHAR_GAP: seg.units = (char_r == " ") ? UnitWordGap : UnitLetGap;
      EM_WORD_GAP: seg.units = UnitWordGap;
      default:     seg.units = UnitDot;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PcChr;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= op ? PcSos : PcChr;
    end else if (advance) begin
      pc <= pc_next;
      if (uw.jmp == J_END) begin
        busy <= 1'b0;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (start) begin
      char_r <= char_code;
    end
    if (advance) begin
      cnt  <= cnt_next;
      bits <= bits_next;
    end
  end

endmodule

FILE: rtl/core/morse_character_keyer_unit.sv
// ---------------------------------------------------------------------------
// morse_character_keyer_unit
// Turns a character or an SOS request into timed keying segments.
// ---------------------------------------------------------------------------
// An accepted request first runs a load step; the first segment is then
// registered in the output register. The microprogram requests one segment per
// cycle while the output slot is free, plus one load step per Morse code.
// The next request is taken once the sequencer has queued the last segment.
// Reset: synchronous, clears the sequencer and output valid; dot time to 60 ms.
`include "assert_macros.svh"

module morse_character_keyer_unit (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] op (0 character, 1 SOS)
  // segment stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] key_on, [13:1] duration_ms, [15:14] zero
  output logic        m_tlast,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mck_pkg::*;

  logic            busy;
  logic            start;
  logic            slot_free;
  seg_req_t        seg;
  logic [DotW-1:0] dot_time;
  logic            key_r;
  logic [DurW-1:0] dur_r;
  logic            last_r;
  logic [DurW-1:0] dur_calc;

  assign s_tready  = !busy && !rst;
  assign start     = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  mck_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (s_tuser),
    .char_code (s_tdata),
    .slot_free (slot_free),
    .busy      (busy),
    .seg       (seg)
  );

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DOT_TIME) ? {22'd0, dot_time} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time <= DotReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DOT_TIME) begin
      dot_time <= pwdata[DotW-1:0];
    end
  end

  // segment length: units times dot time
  assign dur_calc = DurW'({3'd0, dot_time} * {10'd0, seg.units});

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_tvalid <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && seg.valid) begin
      key_r  <= seg.key_on;
      dur_r  <= dur_calc;
      last_r <= seg.last;
    end
  end

  assign m_tdata = {2'b00, dur_r, key_r};
  assign m_tlast = last_r;

  // checks
  `MCK_ASSERT(a_start_busy, clk, rst, start |=> busy)
  `MCK_ASSERT(a_last_done, clk, rst, (seg.valid && seg.last && slot_free) |=> !busy)
  `MCK_ASSERT(a_on_units, clk, rst,
    (seg.valid && seg.key_on) |-> (seg.units == UnitDot || seg.units == UnitDash))

endmodule
